// ----- sv/resp2sp_pkg.sv -----
// ----------------------------------------------------------------------------
// resp2sp_pkg
// Shared constants, result record and helper functions for the RESP2 reply
// stream parser.
// ----------------------------------------------------------------------------
package resp2sp_pkg;

    localparam int MAX_DEPTH  = 8;
    localparam int LEN_BITS   = 32;
    localparam int SP_W       = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int NUM_W      = 64;
    localparam int ACC_X_W    = NUM_W + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [ACC_X_W-1:0] LIM_NEG = ACC_X_W'(1) << 63;
    localparam logic [ACC_X_W-1:0] LIM_INT = LIM_NEG - ACC_X_W'(1);
    localparam logic [ACC_X_W-1:0] LIM_LEN = (ACC_X_W'(1) << LEN_BITS) - ACC_X_W'(1);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] ET_SIMPLE = 3'd0;
    localparam logic [2:0] ET_ERROR  = 3'd1;
    localparam logic [2:0] ET_INT    = 3'd2;
    localparam logic [2:0] ET_BULK   = 3'd3;
    localparam logic [2:0] ET_ARRAY  = 3'd4;

    typedef struct packed {
        logic             content_valid;
        logic [7:0]       content_byte;
        logic             element_done;
        logic [2:0]       element_type;
        logic             element_null;
        logic [NUM_W-1:0] number_value;
        logic [3:0]       nest_depth;
        logic             frame_done;
        logic             protocol_error;
        logic             last_of_byte;
    } result_t;

    function automatic logic [3:0] depth_of(input logic [SP_W-1:0] sp);
        logic [NUM_W-1:0] w;
        w = NUM_W'(sp);
        return w[3:0];
    endfunction

    function automatic result_t res_content(input logic [7:0] b);
        result_t r;
        r = '0;
        r.content_valid = 1'b1;
        r.content_byte  = b;
        return r;
    endfunction

    function automatic result_t res_element(input logic [2:0] etype, input logic is_null,
                                            input logic [NUM_W-1:0] num,
                                            input logic [3:0] depth, input logic frame);
        result_t r;
        r = '0;
        r.element_done = 1'b1;
        r.element_type = etype;
        r.element_null = is_null;
        r.number_value = num;
        r.nest_depth   = depth;
        r.frame_done   = frame;
        return r;
    endfunction

    function automatic result_t res_error();
        result_t r;
        r = '0;
        r.protocol_error = 1'b1;
        return r;
    endfunction

endpackage

// ----- sv/resp2_stream_parser.sv -----
// ----------------------------------------------------------------------------
// resp2_stream_parser
// Byte-serial RESP2 reply tokenizer: streams string payload bytes, reports
// completed elements with their number, nesting depth and end of reply.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on s_ and emits 0, 1 or 2 result items per
// byte on m_, the last of them marked by m_last_of_byte. A byte is taken into
// the input register and parsed from it into a 4-entry result queue, from
// which its results are offered on m_. With m_ready held high the block
// sustains one byte per cycle as long as bytes yield at most one item each;
// s_ready drops only when the result queue has fewer than two free entries.
// Array nesting is tracked in an 8-level stack of remaining element counts;
// closing several levels at once is resolved in the same cycle. Bad prefixes,
// decimal overflow and excess nesting set a sticky error that only reset
// clears. No clearing pass after reset.
module resp2_stream_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_content_valid,
    output logic [7:0]         m_content_byte,
    output logic               m_element_done,
    output logic [2:0]         m_element_type,
    output logic               m_element_null,
    output logic signed [63:0] m_number_value,
    output logic [3:0]         m_nest_depth,
    output logic               m_frame_done,
    output logic               m_protocol_error,
    output logic               m_last_of_byte
);
    import resp2sp_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_LINE,
        PH_NUM,
        PH_PAYLOAD,
        PH_TRAILER,
        PH_ERROR
    } phase_t;

    // input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             fire;

    // parser state
    phase_t            phase_reg, phase_next;
    logic [2:0]        type_reg, type_next;
    logic [NUM_W-1:0]  acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic              seen_reg, seen_next;
    logic              stop_reg, stop_next;
    logic              pcr_reg, pcr_next;
    logic [LEN_BITS-1:0] bulk_reg, bulk_next;
    logic [1:0]        trail_reg, trail_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic              err_reg, err_next;

    // nesting stack
    logic [LEN_BITS-1:0] stack_reg [MAX_DEPTH];
    logic                one_reg   [MAX_DEPTH];
    logic                stk_we;
    logic [IDX_W-1:0]    stk_widx;
    logic [LEN_BITS-1:0] stk_wdata;
    logic                stk_wone;

    // result queue
    result_t           fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, rd_reg;
    logic [FIFO_CW-1:0] cnt_reg;
    result_t           res0, res1, head;
    logic [1:0]        n_res;
    logic              pop;

    // element completion and unwind
    logic [SP_W-1:0]     fin_sp;
    logic [IDX_W-1:0]    dec_idx;
    logic [SP_W-1:0]     dec_pos;
    logic [LEN_BITS-1:0] dec_cur;
    logic                fin_en, err_en;
    logic [2:0]          fin_type;
    logic                fin_null;
    logic [NUM_W-1:0]    fin_num;

    // decimal step
    logic [7:0]          b;
    logic [3:0]          digit;
    logic                is_digit;
    logic [ACC_X_W-1:0]  acc_x10, limit;
    logic                ovf;
    logic                is_null;
    logic [NUM_W-1:0]    sval;

    assign fire    = in_valid_reg && (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign s_ready = !in_valid_reg || fire;
    assign b       = in_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // pop every full level above the deepest one with more than one left
    always_comb begin
        fin_sp = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if ((SP_W'(i) < sp_reg) && !one_reg[i]) begin
                fin_sp = SP_W'(i + 1);
            end
        end
        dec_pos = fin_sp - SP_W'(1);
        dec_idx = dec_pos[IDX_W-1:0];
        dec_cur = stack_reg[dec_idx];
    end

    always_comb begin
        digit    = 4'(b - CH_ZERO);
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + ACC_X_W'(digit);
        if (neg_reg) begin
            limit = LIM_NEG;
        end else if (type_reg == ET_INT) begin
            limit = LIM_INT;
        end else begin
            limit = LIM_LEN;
        end
        ovf     = acc_x10 > limit;
        is_null = !seen_reg || (neg_reg && (acc_reg != '0));
        sval    = neg_reg ? (NUM_W'(0) - acc_reg) : acc_reg;
    end

    always_comb begin
        phase_next = phase_reg;
        type_next  = type_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        stop_next  = stop_reg;
        pcr_next   = pcr_reg;
        bulk_next  = bulk_reg;
        trail_next = trail_reg;
        sp_next    = sp_reg;
        err_next   = err_reg;
        stk_we     = 1'b0;
        stk_widx   = dec_idx;
        stk_wdata  = dec_cur - LEN_BITS'(1);
        stk_wone   = (dec_cur == LEN_BITS'(2));
        res0       = '0;
        res1       = '0;
        n_res      = 2'd0;
        fin_en     = 1'b0;
        err_en     = 1'b0;
        fin_type   = ET_SIMPLE;
        fin_null   = 1'b0;
        fin_num    = '0;

        if (fire) begin
            unique case (phase_reg)
                PH_PREFIX: begin
                    acc_next  = '0;
                    neg_next  = 1'b0;
                    seen_next = 1'b0;
                    stop_next = 1'b0;
                    pcr_next  = 1'b0;
                    unique case (b)
                        CH_PLUS: begin
                            type_next  = ET_SIMPLE;
                            phase_next = PH_LINE;
                        end
                        CH_MINUS: begin
                            type_next  = ET_ERROR;
                            phase_next = PH_LINE;
                        end
                        CH_COLON: begin
                            type_next  = ET_INT;
                            phase_next = PH_NUM;
                        end
                        CH_DOLLAR: begin
                            type_next  = ET_BULK;
                            phase_next = PH_NUM;
                        end
                        CH_STAR: begin
                            type_next  = ET_ARRAY;
                            phase_next = PH_NUM;
                        end
                        default: begin
                            err_en = 1'b1;
                        end
                    endcase
                end
                PH_LINE: begin
                    if (pcr_reg && (b == CH_LF)) begin
                        pcr_next = 1'b0;
                        fin_en   = 1'b1;
                        fin_type = type_reg;
                    end else begin
                        pcr_next = (b == CH_CR);
                        if (pcr_reg) begin
                            res0 = res_content(CH_CR);
                            if (b != CH_CR) begin
                                res1  = res_content(b);
                                n_res = 2'd2;
                            end else begin
                                n_res = 2'd1;
                            end
                        end else if (b != CH_CR) begin
                            res0  = res_content(b);
                            n_res = 2'd1;
                        end
                    end
                end
                PH_NUM: begin
                    if (pcr_reg && (b == CH_LF)) begin
                        pcr_next = 1'b0;
                        if (type_reg == ET_INT) begin
                            fin_en   = 1'b1;
                            fin_type = ET_INT;
                            fin_num  = sval;
                        end else if (type_reg == ET_BULK) begin
                            if (is_null) begin
                                fin_en   = 1'b1;
                                fin_type = ET_BULK;
                                fin_null = 1'b1;
                                fin_num  = '1;
                            end else begin
                                bulk_next  = acc_reg[LEN_BITS-1:0];
                                trail_next = 2'd2;
                                phase_next = (acc_reg == '0) ? PH_TRAILER : PH_PAYLOAD;
                            end
                        end else begin
                            if (is_null) begin
                                fin_en   = 1'b1;
                                fin_type = ET_ARRAY;
                                fin_null = 1'b1;
                                fin_num  = '1;
                            end else if (acc_reg == '0) begin
                                fin_en   = 1'b1;
                                fin_type = ET_ARRAY;
                            end else if (sp_reg >= SP_W'(MAX_DEPTH)) begin
                                err_en = 1'b1;
                            end else begin
                                res0       = res_element(ET_ARRAY, 1'b0, acc_reg,
                                                         depth_of(sp_reg), 1'b0);
                                n_res      = 2'd1;
                                stk_we     = 1'b1;
                                stk_widx   = sp_reg[IDX_W-1:0];
                                stk_wdata  = acc_reg[LEN_BITS-1:0];
                                stk_wone   = (acc_reg == NUM_W'(1));
                                sp_next    = sp_reg + SP_W'(1);
                                phase_next = PH_PREFIX;
                            end
                        end
                    end else begin
                        pcr_next = (b == CH_CR);
                        if (!stop_reg) begin
                            if ((b == CH_MINUS) && !seen_reg && !neg_reg) begin
                                neg_next = 1'b1;
                            end else if (!is_digit) begin
                                stop_next = 1'b1;
                            end else if (ovf) begin
                                err_en = 1'b1;
                            end else begin
                                acc_next  = acc_x10[NUM_W-1:0];
                                seen_next = 1'b1;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res0      = res_content(b);
                    n_res     = 2'd1;
                    bulk_next = bulk_reg - LEN_BITS'(1);
                    if (bulk_reg == LEN_BITS'(1)) begin
                        trail_next = 2'd2;
                        phase_next = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    if (trail_reg > 2'd1) begin
                        trail_next = trail_reg - 2'd1;
                    end else begin
                        trail_next = 2'd0;
                        fin_en     = 1'b1;
                        fin_type   = ET_BULK;
                        fin_num    = acc_reg;
                    end
                end
                default: begin
                    err_en = 1'b1;
                end
            endcase

            if (fin_en) begin
                res0       = res_element(fin_type, fin_null, fin_num, depth_of(sp_reg),
                                         fin_sp == '0);
                n_res      = 2'd1;
                sp_next    = fin_sp;
                stk_we     = (fin_sp != '0);
                phase_next = PH_PREFIX;
            end
            if (err_en) begin
                res0       = res_error();
                n_res      = 2'd1;
                err_next   = 1'b1;
                phase_next = PH_ERROR;
            end
            if (n_res == 2'd1) begin
                res0.last_of_byte = 1'b1;
            end
            if (n_res == 2'd2) begin
                res1.last_of_byte = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            type_reg  <= ET_SIMPLE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            stop_reg  <= 1'b0;
            pcr_reg   <= 1'b0;
            bulk_reg  <= '0;
            trail_reg <= '0;
            sp_reg    <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            stop_reg  <= stop_next;
            pcr_reg   <= pcr_next;
            bulk_reg  <= bulk_next;
            trail_reg <= trail_next;
            sp_reg    <= sp_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_reg[stk_widx] <= stk_wdata;
            one_reg[stk_widx]   <= stk_wone;
        end
    end

    // result queue
    assign pop  = m_valid && m_ready;
    assign head = fifo_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + FIFO_AW'(n_res);
            rd_reg  <= rd_reg + FIFO_AW'(pop);
            cnt_reg <= cnt_reg + FIFO_CW'(n_res) - FIFO_CW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_reg[wr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_reg + FIFO_AW'(1)] <= res1;
        end
    end

    assign m_valid          = (cnt_reg != '0);
    assign m_content_valid  = head.content_valid;
    assign m_content_byte   = head.content_byte;
    assign m_element_done   = head.element_done;
    assign m_element_type   = head.element_type;
    assign m_element_null   = head.element_null;
    assign m_number_value   = head.number_value;
    assign m_nest_depth     = head.nest_depth;
    assign m_frame_done     = head.frame_done;
    assign m_protocol_error = head.protocol_error;
    assign m_last_of_byte   = head.last_of_byte;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_W'(MAX_DEPTH))
        else $error("nesting stack beyond its depth");

    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |=> err_reg)
        else $error("protocol error cleared without reset");

    a_error_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg == (phase_reg == PH_ERROR))
        else $error("error flag and parse phase disagree");
`endif

endmodule

// ----- verif/tb_resp2_stream_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_resp2_stream_parser
// Self-checking bench for the RESP2 reply tokenizer. Feeds directed and
// random reply streams byte by byte, mostly under random source and sink
// stalls, predicts every result item per byte and checks each one as it leaves.
// The sticky protocol error is exercised once, at the tail of the run.
// ----------------------------------------------------------------------------
module tb_resp2_stream_parser;
    import resp2sp_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    typedef enum bit [2:0] {
        PH_PREFIX, PH_LINE, PH_NUM, PH_PAYLOAD, PH_TRAILER, PH_ERROR
    } parse_phase_t;

    class reply_scoreboard;
        parse_phase_t phase;
        bit [2:0]     cur_type;
        bit [63:0]    acc;
        bit           neg;
        bit           got_digit;
        bit           digits_done;
        bit           cr_held;
        bit [63:0]    payload_left;
        int           skip_left;
        bit [63:0]    open_counts [MAX_DEPTH];
        int           nest_ptr;
        bit           sticky_err;
        result_t      step_results[$];
        result_t      expected_q[$];
        int           failures;

        function new();
            phase        = PH_PREFIX;
            cur_type     = '0;
            acc          = '0;
            neg          = 1'b0;
            got_digit    = 1'b0;
            digits_done  = 1'b0;
            cr_held      = 1'b0;
            payload_left = '0;
            skip_left    = 0;
            nest_ptr     = 0;
            sticky_err   = 1'b0;
            failures     = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void emit(result_t r);
            if (step_results.size() >= 2) return;
            r.protocol_error = sticky_err;
            r.last_of_byte   = 1'b0;
            step_results.insert(step_results.size(), r);
        endfunction

        function void emit_content(bit [7:0] b);
            result_t r;
            r = '0;
            r.content_valid = 1'b1;
            r.content_byte  = b;
            emit(r);
        endfunction

        function result_t element(bit [2:0] etype, bit is_null, bit [63:0] num, int depth,
                                  bit frame);
            result_t r;
            r = '0;
            r.element_done = 1'b1;
            r.element_type = etype;
            r.element_null = is_null;
            r.number_value = num;
            r.nest_depth   = depth[3:0];
            r.frame_done   = frame;
            return r;
        endfunction

        function void raise_err();
            sticky_err = 1'b1;
            phase      = PH_ERROR;
            emit('0);
        endfunction

        function void close_element(bit [2:0] etype, bit is_null, bit [63:0] num);
            int depth;
            depth = nest_ptr;
            while (nest_ptr > 0 && nest_ptr <= MAX_DEPTH) begin
                open_counts[nest_ptr-1] -= 64'd1;
                if (open_counts[nest_ptr-1] != 0) break;
                nest_ptr--;
            end
            emit(element(etype, is_null, num, depth, nest_ptr == 0));
            phase = PH_PREFIX;
        endfunction

        // returns 0 on decimal overflow
        function bit digit_step(bit [7:0] b);
            bit [63:0] lim;
            bit [63:0] d;
            if (digits_done) return 1'b1;
            if (b == CH_MINUS && !got_digit && !neg) begin
                neg = 1'b1;
                return 1'b1;
            end
            if (b < CH_ZERO || b > CH_NINE) begin
                digits_done = 1'b1;
                return 1'b1;
            end
            if (neg) lim = 64'h8000_0000_0000_0000;
            else if (cur_type == ET_INT) lim = 64'h7FFF_FFFF_FFFF_FFFF;
            else lim = (64'd1 << LEN_BITS) - 64'd1;
            d = 64'(b) - 64'(CH_ZERO);
            if (acc > (lim - d) / 64'd10) return 1'b0;
            acc       = acc * 64'd10 + d;
            got_digit = 1'b1;
            return 1'b1;
        endfunction

        function void number_done();
            bit [63:0] sval;
            bit        is_null;
            sval    = neg ? (64'd0 - acc) : acc;
            is_null = !got_digit || (neg && acc != 0);
            if (cur_type == ET_INT) begin
                close_element(ET_INT, 1'b0, sval);
            end else if (cur_type == ET_BULK) begin
                if (is_null) begin
                    close_element(ET_BULK, 1'b1, '1);
                end else begin
                    payload_left = acc;
                    skip_left    = 2;
                    phase        = (acc == 0) ? PH_TRAILER : PH_PAYLOAD;
                end
            end else begin
                if (is_null) begin
                    close_element(ET_ARRAY, 1'b1, '1);
                end else if (acc == 0) begin
                    close_element(ET_ARRAY, 1'b0, '0);
                end else if (nest_ptr >= MAX_DEPTH) begin
                    raise_err();
                end else begin
                    emit(element(ET_ARRAY, 1'b0, acc, nest_ptr, 1'b0));
                    open_counts[nest_ptr] = acc;
                    nest_ptr++;
                    phase = PH_PREFIX;
                end
            end
        endfunction

        function void note_byte(bit [7:0] b);
            step_results.delete();
            case (phase)
                PH_PREFIX: begin
                    acc         = '0;
                    neg         = 1'b0;
                    got_digit   = 1'b0;
                    digits_done = 1'b0;
                    cr_held     = 1'b0;
                    if (b == CH_PLUS) begin
                        cur_type = ET_SIMPLE;
                        phase    = PH_LINE;
                    end else if (b == CH_MINUS) begin
                        cur_type = ET_ERROR;
                        phase    = PH_LINE;
                    end else if (b == CH_COLON) begin
                        cur_type = ET_INT;
                        phase    = PH_NUM;
                    end else if (b == CH_DOLLAR) begin
                        cur_type = ET_BULK;
                        phase    = PH_NUM;
                    end else if (b == CH_STAR) begin
                        cur_type = ET_ARRAY;
                        phase    = PH_NUM;
                    end else begin
                        raise_err();
                    end
                end
                PH_LINE: begin
                    if (cr_held && b == CH_LF) begin
                        cr_held = 1'b0;
                        close_element(cur_type, 1'b0, '0);
                    end else begin
                        if (cr_held) emit_content(CH_CR);
                        cr_held = (b == CH_CR);
                        if (!cr_held) emit_content(b);
                    end
                end
                PH_NUM: begin
                    if (cr_held && b == CH_LF) begin
                        cr_held = 1'b0;
                        number_done();
                    end else begin
                        cr_held = (b == CH_CR);
                        if (!digit_step(b)) raise_err();
                    end
                end
                PH_PAYLOAD: begin
                    emit_content(b);
                    payload_left -= 64'd1;
                    if (payload_left == 0) begin
                        skip_left = 2;
                        phase     = PH_TRAILER;
                    end
                end
                PH_TRAILER: begin
                    if (skip_left > 1) begin
                        skip_left--;
                    end else begin
                        skip_left = 0;
                        close_element(ET_BULK, 1'b0, acc);
                    end
                end
                default: begin
                    sticky_err = 1'b1;
                    phase      = PH_ERROR;
                    emit('0);
                end
            endcase
            if (step_results.size() > 0)
                step_results[step_results.size()-1].last_of_byte = 1'b1;
            foreach (step_results[i]) expected_q.insert(expected_q.size(), step_results[i]);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected result item: %p", got);
                return;
            end
            want = expected_q.pop_front();
            if (got.content_valid !== want.content_valid ||
                got.content_byte !== want.content_byte ||
                got.element_done !== want.element_done ||
                got.element_type !== want.element_type ||
                got.element_null !== want.element_null ||
                got.number_value !== want.number_value ||
                got.nest_depth !== want.nest_depth ||
                got.frame_done !== want.frame_done ||
                got.protocol_error !== want.protocol_error ||
                got.last_of_byte !== want.last_of_byte) begin
                failures++;
                if (failures <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_content_valid;
    logic [7:0]         m_content_byte;
    logic               m_element_done;
    logic [2:0]         m_element_type;
    logic               m_element_null;
    logic signed [63:0] m_number_value;
    logic [3:0]         m_nest_depth;
    logic               m_frame_done;
    logic               m_protocol_error;
    logic               m_last_of_byte;
    result_t            dut_item;

    int                 src_idle_pct = 19;
    int                 snk_stall_pct = 61;
    int                 quiet_cycles = 0;
    bit [7:0]           tx_q[$];
    reply_scoreboard    sb = new();

    resp2_stream_parser u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_content_valid  (m_content_valid),
        .m_content_byte   (m_content_byte),
        .m_element_done   (m_element_done),
        .m_element_type   (m_element_type),
        .m_element_null   (m_element_null),
        .m_number_value   (m_number_value),
        .m_nest_depth     (m_nest_depth),
        .m_frame_done     (m_frame_done),
        .m_protocol_error (m_protocol_error),
        .m_last_of_byte   (m_last_of_byte)
    );

    assign dut_item = {m_content_valid, m_content_byte, m_element_done, m_element_type,
                       m_element_null, m_number_value, m_nest_depth, m_frame_done,
                       m_protocol_error, m_last_of_byte};

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_byte(s_rx_byte);
        if (aresetn && m_valid && m_ready) sb.check_result(dut_item);
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // reply stream builders
    // ------------------------------------------------------------------------
    function automatic void put_byte(bit [7:0] b);
        tx_q.insert(tx_q.size(), b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void add_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endfunction

    function automatic void add_line(string s);
        add_text(s);
        add_crlf();
    endfunction

    // line filler: never LF right after CR; in a number field it starts on a
    // byte that stops the digits
    function automatic void add_noise(int n, bit num_field);
        bit [7:0] b;
        for (int i = 0; i < n; i++) begin
            do begin
                b = ($urandom_range(0, 11) == 0) ? CH_CR : 8'($urandom_range(0, 255));
            end while ((tx_q.size() > 0 && tx_q[tx_q.size()-1] == CH_CR && b == CH_LF) ||
                       (num_field && i == 0 &&
                        (b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE))));
            put_byte(b);
        end
    endfunction

    function automatic void gen_line(bit [7:0] prefix);
        put_byte(prefix);
        add_noise($urandom_range(0, 12), 1'b0);
        add_crlf();
    endfunction

    function automatic void gen_int();
        longint v;
        put_byte(CH_COLON);
        case ($urandom_range(0, 7))
            0: ;
            1: add_text("-");
            2: begin
                v = longint'({$urandom, $urandom});
                add_text($sformatf("%0d", v));
            end
            3: add_text($sformatf("-%0d", $urandom_range(0, 999)));
            default: add_text($sformatf("%0d", $urandom_range(0, 99999)));
        endcase
        if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 6), 1'b1);
        add_crlf();
    endfunction

    function automatic void gen_bulk();
        int n;
        int m;
        int k;
        put_byte(CH_DOLLAR);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        k = $urandom_range(0, 9);
        if (k == 0) begin
            m = $urandom_range(0, 3);
            add_text($sformatf("-%0d", m));
            n = (m == 0) ? 0 : -1;
        end else if (k == 1) begin
            n = -1;
        end else begin
            add_text($sformatf("%0d", n));
        end
        if ($urandom_range(0, 3) == 0) add_noise($urandom_range(1, 4), 1'b1);
        add_crlf();
        if (n >= 0) begin
            for (int i = 0; i < n + 2; i++) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // dive forces a chain of non-empty arrays down to the stack limit
    function automatic void gen_element(int depth, bit dive);
        int pick;
        int n;
        if (dive && depth < MAX_DEPTH) pick = 8;
        else if (dive) pick = $urandom_range(0, 7);
        else pick = $urandom_range(0, 9);
        if (pick >= 8 && depth >= MAX_DEPTH) pick = 7;
        case (pick)
            0, 1: gen_line(CH_PLUS);
            2: gen_line(CH_MINUS);
            3, 4: gen_int();
            5, 6: gen_bulk();
            7: begin
                case ($urandom_range(0, 2))
                    0: add_line("*0");
                    1: add_line("*-1");
                    default: add_line("*");
                endcase
            end
            default: begin
                n = dive ? $urandom_range(1, 2) : $urandom_range(1, 4);
                put_byte(CH_STAR);
                add_text($sformatf("%0d", n));
                if ($urandom_range(0, 7) == 0) add_noise(2, 1'b1);
                add_crlf();
                for (int i = 0; i < n; i++) gen_element(depth + 1, dive && i == 0);
            end
        endcase
    endfunction

    function automatic void load_directed();
        add_line("+OK");
        add_line("+");
        put_byte(CH_PLUS);
        add_text("a");
        put_byte(CH_CR);
        add_text("b");
        put_byte(CH_CR);
        add_crlf();
        put_byte(CH_MINUS);
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(8'h00);
        put_byte(8'h7F);
        add_crlf();
        add_line("-ERR bad");
        add_line(":0");
        add_line(":-0");
        add_line(":");
        add_line(":-");
        add_line(":--5");
        add_line(":9223372036854775807");
        add_line(":-9223372036854775808");
        add_line(":12ab34");
        add_text(":1");
        put_byte(CH_CR);
        add_line("2");
        add_line("$0");
        add_crlf();
        add_line("$-1");
        add_line("$");
        add_line("$-x");
        add_line("$-0");
        add_text("zz");
        add_line("$3");
        add_text("abc");
        add_crlf();
        add_line("$2");
        add_crlf();
        add_crlf();
        add_line("*0");
        add_line("*-1");
        add_line("*");
        add_line("*2");
        add_line(":1");
        add_line("$1");
        add_text("x");
        add_crlf();
        add_line("*2");
        add_line("*1");
        add_line(":1");
        add_line(":2");
        repeat (MAX_DEPTH) add_line("*1");
        add_line("*0");
        repeat (MAX_DEPTH) add_line("*1");
        add_line("*-1");
        repeat (MAX_DEPTH) add_line("*1");
        add_line(":-7");
    endfunction

    // the error is sticky, so only one kind can be hit per run
    function automatic void load_error_tail();
        bit [7:0] b;
        case ($urandom_range(0, 5))
            0: begin
                do b = 8'($urandom_range(0, 255));
                while (b == CH_PLUS || b == CH_MINUS || b == CH_COLON ||
                       b == CH_DOLLAR || b == CH_STAR);
                put_byte(b);
            end
            1: add_line(":9223372036854775808");
            2: add_line(":-9223372036854775809");
            3: add_line("$4294967296");
            4: add_line("*-9223372036854775809");
            default: repeat (MAX_DEPTH + 1) add_line("*1");
        endcase
        repeat (40) put_byte(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(bit [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_all();
        while (tx_q.size() > 0) send_byte(tx_q.pop_front());
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() > 0) @(posedge aclk);
    endtask

    task automatic run_phase(int src_pct, int snk_pct, int n_bytes);
        int sent;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_bytes) begin
            gen_element(0, $urandom_range(0, 7) == 0);
            sent += tx_q.size();
            send_all();
        end
        drain();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_directed();
        send_all();
        run_phase(19, 61, 430);
        run_phase(61, 19, 430);
        run_phase(0, 0, 430);
        load_error_tail();
        send_all();
        drain();
        repeat (16) @(posedge aclk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
